// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk, ignored while rst_n is low.
`define UCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, but also held during reset.
`define UCF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ucf_pkg.sv =====
// Types, constants and helper functions of the UDP/IPv4 length and checksum filler.
package ucf_pkg;

  localparam int unsigned PosW = 12;
  localparam int unsigned LenW = 13;
  localparam int unsigned IpSumW = 20;
  localparam int unsigned UdpSumW = 28;

  localparam logic [LenW-1:0] EthHdrLen = 13'h00E;
  localparam logic [LenW-1:0] UdpOffset = 13'h022;
  localparam logic [LenW-1:0] MinFrame = 13'd42;
  localparam logic [PosW-1:0] IpHdrStart = 12'h00E;
  localparam logic [PosW-1:0] IpHdrEnd = 12'h022;
  localparam logic [PosW-1:0] IpLenOff = 12'd16;
  localparam logic [PosW-1:0] IpCsumOff = 12'd24;
  localparam logic [PosW-1:0] IpAddrOff = 12'd26;
  localparam logic [PosW-1:0] UdpLenOff = 12'd38;
  localparam logic [PosW-1:0] UdpCsumOff = 12'd40;
  localparam logic [15:0] ProtoUdp = 16'h0011;
  localparam logic [15:0] CsumAllOnes = 16'hFFFF;

  typedef struct packed {
    logic        frame_error;
    logic [15:0] udp_checksum;
    logic [15:0] ip_header_checksum;
    logic [10:0] udp_length;
    logic [10:0] ip_total_length;
  } ucf_result_t;

  // Ones'-complement fold of a 32-bit sum down to 16 bits.
  function automatic logic [15:0] fold16(input logic [31:0] s);
    logic [16:0] a;
    logic [16:0] b;
    a = 17'(s[15:0]) + 17'(s[31:16]);
    b = 17'(a[15:0]) + 17'(a[16]);
    return b[15:0];
  endfunction

endpackage

// ===== hw/rtl/udp_ipv4_length_checksum_fill.sv =====
// Top level of the UDP/IPv4 length and checksum filler.
//
// The in_ channel takes an Ethernet frame one byte per word, in wire order, with
// in_tlast on the last byte. The frame holds an IPv4 header at byte 14 and a UDP
// header at byte 34. For each frame the out_ channel gives one word: IP total
// length, UDP length, IP header checksum and UDP checksum in out_tdata, and a
// frame error flag in out_tuser (frame shorter than 42 bytes or longer than
// MAX_FRAME; all other fields are then zero).
// Throughput is one byte per cycle, except that a last byte waits while the
// output register is not free. Each byte is held in the input register, and the
// frame result is written to the output register as the last byte leaves it.
// The running sums are updated by one short add per byte, and the final folds
// run in the cycle that holds the last byte.
// Reset clears the input and output valid flags and all running sums.
// When the receiver stalls, the result waits in the output register and bytes
// of the next frame keep flowing; only a last byte waits in the input register
// until the output register is free.
module udp_ipv4_length_checksum_fill
  import ucf_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [10:0] ip_total_length, [21:11] udp_length, [37:22] ip_header_checksum,
  // [53:38] udp_checksum, [55:54] zero
  output logic [55:0] out_tdata,
  output logic        out_tuser   // [0] frame_error
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        out_valid_r;
  ucf_result_t out_res_r;
  ucf_result_t result;
  logic        out_free;
  logic        s1_fire;

  assign out_free = !out_valid_r || out_tready;
  assign s1_fire = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  ucf_accum #(
    .MAX_FRAME(MAX_FRAME)
  ) u_accum (
    .clk(clk),
    .rst_n(rst_n),
    .byte_valid(s1_fire),
    .frame_byte(s1_byte_r),
    .end_of_frame(s1_last_r),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {2'b00, out_res_r.udp_checksum, out_res_r.ip_header_checksum,
                      out_res_r.udp_length, out_res_r.ip_total_length};
  assign out_tuser = out_res_r.frame_error;

endmodule

// ===== hw/rtl/ucf_accum.sv =====
// Per-byte word pairing, running checksum sums and end-of-frame result logic.
module ucf_accum
  import ucf_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_valid,
  input  logic [7:0]  frame_byte,
  input  logic        end_of_frame,
  output ucf_result_t result
);

  localparam logic [PosW-1:0] LastPos = PosW'(MAX_FRAME - 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_FRAME);

  logic [PosW-1:0]    pos_r, pos_nxt;
  logic [IpSumW-1:0]  ip_sum_r, ip_sum_nxt;
  logic [UdpSumW-1:0] udp_sum_r, udp_sum_nxt;
  logic [7:0]         held_r, held_nxt;
  logic               too_long_r, too_long_nxt;

  logic [PosW-1:0]    start;
  logic [15:0]        word;
  logic               ip_add, udp_add;
  logic [IpSumW-1:0]  ip_sum_add;
  logic [UdpSumW-1:0] udp_sum_add;
  logic [LenW-1:0]    len;
  logic [LenW-1:0]    ip_len, udp_len;
  logic               err;
  logic [20:0]        ip_pre;
  logic [29:0]        udp_pre;
  logic [15:0]        udp_pad;
  logic [15:0]        ipc, udc;

  always_comb begin
    start = pos_r - PosW'(1);
    word = {held_r, frame_byte};
    // A word is complete when the byte at an odd position arrives.
    ip_add = !too_long_r && pos_r[0] && (start >= IpHdrStart) && (start < IpHdrEnd) &&
             (start != IpLenOff) && (start != IpCsumOff);
    udp_add = !too_long_r && pos_r[0] && (start >= IpAddrOff) &&
              (start != UdpLenOff) && (start != UdpCsumOff);
    ip_sum_add = ip_sum_r + (ip_add ? IpSumW'(word) : '0);
    udp_sum_add = udp_sum_r + (udp_add ? UdpSumW'(word) : '0);

    len = LenW'(pos_r) + LenW'(1);
    ip_len = len - EthHdrLen;
    udp_len = len - UdpOffset;
    err = too_long_r || (len < MinFrame) || (len > MaxLen);
    // An odd final byte is padded with a zero low byte.
    udp_pad = len[0] ? {frame_byte, 8'h00} : 16'h0000;

    ip_pre = 21'(ip_sum_add) + 21'(ip_len);
    // The UDP length is counted in both the pseudo-header and the UDP header.
    udp_pre = 30'(udp_sum_add) + 30'(udp_pad) + 30'(ProtoUdp) + 30'({udp_len, 1'b0});
    ipc = ~fold16(32'(ip_pre));
    udc = ~fold16(32'(udp_pre));
    if (udc == 16'h0000) begin
      udc = CsumAllOnes;
    end

    if (err) begin
      result = '0;
      result.frame_error = 1'b1;
    end else begin
      result.frame_error = 1'b0;
      result.udp_checksum = udc;
      result.ip_header_checksum = ipc;
      result.udp_length = udp_len[10:0];
      result.ip_total_length = ip_len[10:0];
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    ip_sum_nxt = ip_sum_r;
    udp_sum_nxt = udp_sum_r;
    held_nxt = held_r;
    too_long_nxt = too_long_r;
    if (byte_valid) begin
      if (end_of_frame) begin
        pos_nxt = '0;
        ip_sum_nxt = '0;
        udp_sum_nxt = '0;
        held_nxt = '0;
        too_long_nxt = 1'b0;
      end else if (!too_long_r) begin
        ip_sum_nxt = ip_sum_add;
        udp_sum_nxt = udp_sum_add;
        if (!pos_r[0]) begin
          held_nxt = frame_byte;
        end
        // Past the maximum length nothing more is counted or summed.
        if (pos_r >= LastPos) begin
          too_long_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ip_sum_r <= '0;
      udp_sum_r <= '0;
      held_r <= '0;
      too_long_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      ip_sum_r <= ip_sum_nxt;
      udp_sum_r <= udp_sum_nxt;
      held_r <= held_nxt;
      too_long_r <= too_long_nxt;
    end
  end

endmodule

// ===== hw/rtl/ucf_checker.sv =====
// Port-level checks on the result channel of the filler, bound to the top level.
`include "assert_macros.svh"

module ucf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tuser
);

  // A frame in error carries no lengths or checksums.
  `UCF_ASSERT(a_err_zero, (out_tvalid && out_tuser) |-> (out_tdata == 56'h0), "error word has nonzero fields")

  // A good frame never sends a zero UDP checksum.
  `UCF_ASSERT(a_udp_nonzero, (out_tvalid && !out_tuser) |-> (out_tdata[53:38] != 16'h0000), "zero UDP checksum sent")

  // The two lengths differ by the size of the IPv4 header.
  `UCF_ASSERT(a_len_rel, (out_tvalid && !out_tuser) |-> (out_tdata[10:0] == (out_tdata[21:11] + 11'd20)), "IP and UDP lengths disagree")

  // A stalled result holds until it is taken.
  `UCF_ASSERT(a_stall_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "stalled result changed")

endmodule

bind udp_ipv4_length_checksum_fill ucf_checker u_ucf_checker (.*);

// ===== sim/ucf_frame_checker.sv =====
// Checker that predicts the length and checksum result of each frame and compares it.
`timescale 1ns / 100ps

module ucf_frame_checker
  import ucf_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending
);

  logic [PosW-1:0] byte_pos = '0;
  logic [31:0]     ip_acc = '0;
  logic [31:0]     udp_acc = '0;
  logic [7:0]      high_byte = '0;
  logic            overlong = 1'b0;
  int              errors = 0;
  ucf_result_t     frame_results [$];
  ucf_result_t     seen;
  ucf_result_t     want;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [15:0] fold_ones(input logic [31:0] s);
    logic [31:0] v;
    v = s;
    while (v[31:16] != 16'h0000) v = {16'h0000, v[15:0]} + {16'h0000, v[31:16]};
    return v[15:0];
  endfunction

  // The length and checksum fields of both headers are left out of the sums;
  // the computed lengths are added back when the frame ends.
  task automatic add_pair(input logic [PosW-1:0] start, input logic [15:0] pair);
    if (start >= IpHdrStart && start < IpHdrEnd) begin
      if (start != IpLenOff && start != IpCsumOff) ip_acc += pair;
      if (start >= IpAddrOff) udp_acc += pair;
    end else if (start >= IpHdrEnd) begin
      if (start != UdpLenOff && start != UdpCsumOff) udp_acc += pair;
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    logic [PosW-1:0] pos;
    int unsigned     len;
    ucf_result_t     r;
    pos = byte_pos;
    if (!overlong) begin
      if (pos[0]) add_pair(pos - 1'b1, {high_byte, b});
      else high_byte = b;
      if (!last) begin
        if (pos >= MAX_FRAME - 1) overlong = 1'b1;
        else byte_pos = pos + 1'b1;
      end
    end
    if (last) begin
      len = pos + 1;
      r = '0;
      if (overlong || len < MinFrame || len > MAX_FRAME) begin
        r.frame_error = 1'b1;
      end else begin
        // An odd last byte is the high half of a word padded with zero.
        if (len % 2 == 1) udp_acc += {16'h0000, b, 8'h00};
        r.ip_total_length = 11'(len - EthHdrLen);
        r.udp_length = 11'(len - UdpOffset);
        r.ip_header_checksum = ~fold_ones(ip_acc + (len - EthHdrLen));
        // The UDP length is counted in the pseudo-header and in the UDP header.
        r.udp_checksum = ~fold_ones(udp_acc + ProtoUdp + 2 * (len - UdpOffset));
        if (r.udp_checksum == 16'h0000) r.udp_checksum = CsumAllOnes;
      end
      frame_results.push_back(r);
      byte_pos = '0;
      ip_acc = '0;
      udp_acc = '0;
      high_byte = '0;
      overlong = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        seen = {out_tuser, out_tdata[53:0]};
        if (frame_results.size() == 0) begin
          $display("%0t: result word with none expected: expected nothing, actual %h",
                   $time, seen);
          errors++;
        end else begin
          want = frame_results.pop_front();
          check_field("ip_total_length", want.ip_total_length, seen.ip_total_length);
          check_field("udp_length", want.udp_length, seen.udp_length);
          check_field("ip_header_checksum", want.ip_header_checksum,
                      seen.ip_header_checksum);
          check_field("udp_checksum", want.udp_checksum, seen.udp_checksum);
          check_field("frame_error", want.frame_error, seen.frame_error);
        end
      end
      fail_count <= errors;
      pending <= frame_results.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the testbench: clock, reset, frame stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module testbench
  import ucf_pkg::*;
;

  localparam int unsigned MaxFrame = 2048;
  localparam int unsigned ByteTarget = 1100;
  localparam int unsigned FrameTarget = 12;
  localparam int unsigned CycleLimit = 500000;

  typedef enum logic [1:0] {FillRandom, FillZero, FillOnes, FillFoldEdge} fill_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  int          fail_count;
  int          results_pending;
  int          idle_odds = 0;
  int          stall_left = 0;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          frames_sent = 0;

  always #5 clk = ~clk;

  udp_ipv4_length_checksum_fill #(.MAX_FRAME(MaxFrame)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  ucf_frame_checker #(.MAX_FRAME(MaxFrame)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .fail_count(fail_count), .pending(results_pending)
  );

  // Receiver stalls come in bursts whose length is drawn at random.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [7:0] frame_byte(input fill_t fill, input int idx);
    case (fill)
      FillZero: return 8'h00;
      FillOnes: return 8'hFF;
      // All zero except the first IP word and the UDP source port, picked so
      // that both sums of a 42-byte frame fold to all ones: the IP checksum
      // comes out zero and the UDP checksum is sent as all ones.
      FillFoldEdge: begin
        case (idx)
          14, 34: return 8'hFF;
          15: return 8'hE3;
          35: return 8'hDE;
          default: return 8'h00;
        endcase
      end
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int len, input fill_t fill);
    for (int i = 0; i < len; i++) begin
      if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= frame_byte(fill, i);
      in_tlast <= (i == len - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    bytes_sent += len;
    frames_sent++;
  endtask

  // Holds the sender off until every frame result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  function automatic int random_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return $urandom_range(MinFrame, 90);
    if (pick < 85) return $urandom_range(1, MinFrame - 1);
    if (pick < 97) return $urandom_range(91, 400);
    return $urandom_range(401, 600);
  endfunction

  function automatic int random_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 8;
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    idle_odds = random_odds();
    send_frame(MinFrame, FillFoldEdge);
    idle_odds = random_odds();
    send_frame(MinFrame + 1, FillOnes);
    send_frame(MinFrame - 1, FillRandom);
    send_frame(1, FillZero);
    idle_odds = random_odds();
    send_frame(MinFrame, FillZero);
    send_frame(60, FillRandom);
    drain_results();

    bytes_sent = 0;
    frames_sent = 0;
    while (bytes_sent < ByteTarget || frames_sent < FrameTarget) begin
      idle_odds = random_odds();
      send_frame(random_len(), ($urandom_range(0, 9) == 0) ? FillOnes : FillRandom);
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    // Closing stretch at full rate on both sides.
    idle_odds = 0;
    for (int f = 0; f < 6; f++) send_frame($urandom_range(MinFrame, 90), FillRandom);

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ucf_pkg.sv
hw/rtl/ucf_accum.sv
hw/rtl/udp_ipv4_length_checksum_fill.sv
hw/rtl/ucf_checker.sv
sim/ucf_frame_checker.sv
sim/testbench.sv
